/* src/rcz_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcz_pkg: shared types and constants for the RGB 3x3 convolution unit
// Payload structs, register indexes and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package rcz_pkg;

  localparam int PIX_W          = 8;
  localparam int RGB_W          = 3 * PIX_W;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 8;
  localparam int PROD_W         = PIX_W + COEF_W;
  localparam int SUM_W          = PROD_W + 4;
  localparam int CFG_W          = 48;
  localparam int CFG_IDX_W      = 3;
  localparam int IMG_W_CFG_W    = 11;
  localparam int HEIGHT_W       = 16;
  localparam int PIX_MAX        = 255;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  localparam logic [CFG_W-1:0]    COEF_TOP_RESET = 48'd0;
  localparam logic [CFG_W-1:0]    COEF_MID_RESET = 48'd256;
  localparam logic [CFG_W-1:0]    COEF_BOT_RESET = 48'd0;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 16'd480;
  localparam int                  WIDTH_RESET    = 640;

  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] pix_red;
    logic [PIX_W-1:0] pix_green;
    logic [PIX_W-1:0] pix_blue;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_last;
  } pix_out_t;

  // Per-item decisions from the position counters; index 0 is top row / left column.
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } step_info_t;

endpackage
`default_nettype wire

/* src/rcz_line_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcz_line_buf: two-row line buffer
// Upper and lower row memories indexed by column, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module rcz_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [AW-1:0]            waddr,
  input  wire  [rcz_pkg::RGB_W-1:0] wdata_up,
  input  wire  [rcz_pkg::RGB_W-1:0] wdata_lo,
  input  wire                      re,
  input  wire  [AW-1:0]            raddr,
  output logic [rcz_pkg::RGB_W-1:0] rdata_up,
  output logic [rcz_pkg::RGB_W-1:0] rdata_lo
);
  import rcz_pkg::*;

  logic [RGB_W-1:0] mem_up [DEPTH];
  logic [RGB_W-1:0] mem_lo [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_up[waddr] <= wdata_up;
      mem_lo[waddr] <= wdata_lo;
    end
  end

  // read data holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_up <= mem_up[raddr];
      rdata_lo <= mem_lo[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/rcz_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcz_ctrl: raster position tracking
// Input and output column/row counters; decides per transaction whether it
// is dropped, whether it yields a result, the border mask and frame end.
// ----------------------------------------------------------------------------
module rcz_ctrl #(
  parameter int CW = 10,
  parameter int WW = 11
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           take,
  input  wire                           flush,
  input  wire  [WW-1:0]                 w_eff,
  input  wire  [rcz_pkg::HEIGHT_W-1:0]  h_eff,
  output logic [CW-1:0]                 col,
  output logic                          skip,
  output rcz_pkg::step_info_t           info
);
  import rcz_pkg::*;

  logic [CW-1:0]       in_col, in_col_next, out_col, out_col_next;
  logic [HEIGHT_W-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [WW-1:0]       w_m1;
  logic [HEIGHT_W-1:0] h_m1;
  logic                in_wrap, out_wrap;

  assign w_m1 = w_eff - WW'(1);
  assign h_m1 = h_eff - HEIGHT_W'(1);

  assign col  = in_col;
  // a flush before the first pixel of a frame is dropped
  assign skip = flush && (in_row == '0) && (in_col == '0);

  assign in_wrap  = WW'(in_col) >= w_m1;
  assign out_wrap = WW'(out_col) >= w_m1;

  always_comb begin
    info.emit      = (in_row >= HEIGHT_W'(2)) || ((in_row == HEIGHT_W'(1)) && (in_col != '0));
    info.row_ok[0] = (out_row != '0) && (out_row <= h_eff);
    info.row_ok[1] = out_row < h_eff;
    info.row_ok[2] = out_row < h_m1;
    info.col_ok[0] = (out_col != '0) && (WW'(out_col) <= w_eff);
    info.col_ok[1] = WW'(out_col) < w_eff;
    info.col_ok[2] = WW'(out_col) < w_m1;
    info.last      = info.emit && (out_row >= h_m1) && out_wrap;
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    if (in_wrap) begin
      in_col_next = '0;
      if (in_row != '1) in_row_next = in_row + HEIGHT_W'(1);
    end else begin
      in_col_next = in_col + CW'(1);
    end
    if (info.last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (info.emit) begin
      if (out_wrap) begin
        out_col_next = '0;
        if (out_row != '1) out_row_next = out_row + HEIGHT_W'(1);
      end else begin
        out_col_next = out_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take && !skip) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

endmodule
`default_nettype wire

/* src/rcz_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcz_filter: 3x3 window, multiply and sum stages
// Shifts the window on each step, registers the masked products, then sums,
// floors and clamps into the output register.
// ----------------------------------------------------------------------------
module rcz_filter (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             step,
  input  wire rcz_pkg::step_info_t        info,
  input  wire  [rcz_pkg::RGB_W-1:0]       up,
  input  wire  [rcz_pkg::RGB_W-1:0]       lo,
  input  wire  [rcz_pkg::RGB_W-1:0]       px,
  input  wire  [2:0][rcz_pkg::CFG_W-1:0]  coef_rows,
  output logic                            ready,
  output logic                            out_valid,
  input  wire                             out_ready,
  output rcz_pkg::pix_out_t               out_data
);
  import rcz_pkg::*;

  logic [2:0][2:0][RGB_W-1:0] win, win_next;
  logic signed [PROD_W-1:0]   prod [3][3][3];
  logic signed [PROD_W-1:0]   prod_next [3][3][3];
  logic                       prod_valid, prod_last;
  logic                       ready_out;
  logic [2:0][PIX_W-1:0]      chan_res;

  assign ready_out = !out_valid || out_ready;
  assign ready     = !prod_valid || ready_out;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up;
    win_next[1][2] = lo;
    win_next[2][2] = px;
  end

  // masked neighbours contribute a zero pixel
  always_comb begin
    logic signed [PROD_W-1:0] sv;
    logic signed [PROD_W-1:0] cf;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sv = (info.row_ok[r] && info.col_ok[c]) ?
               PROD_W'(win_next[r][c][(2-ch)*PIX_W +: PIX_W]) : '0;
          cf = PROD_W'($signed(coef_rows[r][c*COEF_W +: COEF_W]));
          prod_next[ch][r][c] = sv * cf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (step) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ready) begin
      prod_valid <= step && info.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      prod      <= prod_next;
      prod_last <= info.last;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic [SUM_W-1:0]        sh;
    for (int ch = 0; ch < 3; ch++) begin
      acc = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          acc = acc + SUM_W'(prod[ch][r][c]);
        end
      end
      sh = SUM_W'(acc >>> COEF_FRAC_BITS);
      if (acc[SUM_W-1]) begin
        chan_res[ch] = '0;
      end else if (sh > SUM_W'(PIX_MAX)) begin
        chan_res[ch] = PIX_W'(PIX_MAX);
      end else begin
        chan_res[ch] = sh[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out) begin
      out_data.out_red    <= chan_res[0];
      out_data.out_green  <= chan_res[1];
      out_data.out_blue   <= chan_res[2];
      out_data.frame_last <= prod_last;
    end
  end

endmodule
`default_nettype wire

/* src/rgb_conv3x3_zero_pad_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_conv3x3_zero_pad_unit: 3x3 convolution of an RGB raster stream
// Applies one signed Q8.8 kernel to all three channels with zero padding.
// ----------------------------------------------------------------------------
// Takes one pixel per clock whenever the result side keeps up; the stream
// runs through an input register, a product register and an output register.
// Results lag pixels by image_width+1 items; after the last pixel of a frame
// send image_width+1 flush items to drain it. A flush before the first pixel
// of a frame is accepted and dropped. Two line buffers of MAX_WIDTH x 24 bits
// hold the previous rows; their contents are never cleared (border masking
// hides unwritten entries), so the block is ready straight after reset. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module rgb_conv3x3_zero_pad_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [rcz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rcz_pkg::CFG_W-1:0]       cfg_data,
  input  wire                             px_valid,
  output logic                            px_ready,
  input  wire rcz_pkg::pix_in_t           px_data,
  output logic                            flt_valid,
  input  wire                             flt_ready,
  output rcz_pkg::pix_out_t               flt_data
);
  import rcz_pkg::*;

  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  // configuration
  logic [2:0][CFG_W-1:0] coef_rows;
  logic [WW-1:0]         w_eff;
  logic [HEIGHT_W-1:0]   h_eff;
  logic [31:0]           w_req;

  assign w_req = 32'(cfg_data[IMG_W_CFG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rows[0] <= COEF_TOP_RESET;
      coef_rows[1] <= COEF_MID_RESET;
      coef_rows[2] <= COEF_BOT_RESET;
      w_eff        <= WW'(W_RESET);
      h_eff        <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_TOP: coef_rows[0] <= cfg_data;
        REG_COEF_MID: coef_rows[1] <= cfg_data;
        REG_COEF_BOT: coef_rows[2] <= cfg_data;
        REG_WIDTH: begin
          if (w_req == '0) w_eff <= WW'(1);
          else if (w_req > 32'(MAX_WIDTH)) w_eff <= WW'(MAX_WIDTH);
          else w_eff <= WW'(w_req);
        end
        REG_HEIGHT: begin
          if (cfg_data[HEIGHT_W-1:0] == '0) h_eff <= HEIGHT_W'(1);
          else h_eff <= cfg_data[HEIGHT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // position control
  logic       take, skip;
  logic [CW-1:0] col_now;
  step_info_t info_now;

  assign take = px_valid && px_ready;

  rcz_ctrl #(.CW(CW), .WW(WW)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .flush (px_data.flush),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .col   (col_now),
    .skip  (skip),
    .info  (info_now)
  );

  // input stage
  logic             a_valid, step, filt_ready;
  logic [RGB_W-1:0] a_px, a_up, a_lo, rd_up, rd_lo;
  logic [CW-1:0]    a_col;
  step_info_t       a_info;
  logic             a_byp;
  logic [RGB_W-1:0] byp_up, byp_lo;
  logic [RGB_W-1:0] px_word;

  assign step     = a_valid && filt_ready;
  assign px_ready = !a_valid || filt_ready;
  assign px_word  = px_data.flush ? '0 :
                    {px_data.pix_red, px_data.pix_green, px_data.pix_blue};

  // the item leaving writes the same column the new one reads: forward it
  assign a_up = a_byp ? byp_up : rd_up;
  assign a_lo = a_byp ? byp_lo : rd_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= !skip;
    end else if (step) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_px   <= px_word;
      a_col  <= col_now;
      a_info <= info_now;
      a_byp  <= step && (a_col == col_now);
      byp_up <= a_lo;
      byp_lo <= a_px;
    end
  end

  rcz_line_buf #(.DEPTH(MAX_WIDTH), .AW(CW)) u_line_buf (
    .clk      (clk),
    .we       (step),
    .waddr    (a_col),
    .wdata_up (a_lo),
    .wdata_lo (a_px),
    .re       (take),
    .raddr    (col_now),
    .rdata_up (rd_up),
    .rdata_lo (rd_lo)
  );

  rcz_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .info      (a_info),
    .up        (a_up),
    .lo        (a_lo),
    .px        (a_px),
    .coef_rows (coef_rows),
    .ready     (filt_ready),
    .out_valid (flt_valid),
    .out_ready (flt_ready),
    .out_data  (flt_data)
  );

  // a stalled input stage keeps its transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !step |=> a_valid && $stable(a_col))
    else $error("input stage lost a transaction");

  // only a flush may be dropped
  drop_flush: assert property (@(posedge clk) disable iff (rst)
    take && skip |-> px_data.flush)
    else $error("pixel dropped at frame start");

  // frame end only marked on a transaction that yields a result
  last_emit: assert property (@(posedge clk) disable iff (rst)
    step && a_info.last |-> a_info.emit)
    else $error("frame end on a transaction without result");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for the RGB 3x3 zero-padded convolution unit
// Streams framed pixel traffic with random idling and back-pressure, predicts
// every filtered pixel and compares each result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rcz_pkg::*;

  localparam int      LINE_DEPTH    = 1024;
  localparam int      SETTLE_CYCLES = 8;
  localparam int      RANDOM_ITEMS  = 520;
  localparam longint  TIMEOUT       = 64'd20_000_000;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } phase_t;

  // Predicts the filtered pixel stream and holds the pixels still owed.
  class conv3x3_predictor;
    logic [CFG_W-1:0]       coef_row [3];
    logic [IMG_W_CFG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [RGB_W-1:0]       line_upper [LINE_DEPTH];
    logic [RGB_W-1:0]       line_lower [LINE_DEPTH];
    logic [RGB_W-1:0]       win [3][3];
    int                     in_col, in_row, out_col, out_row;
    pix_out_t               expected_pixels [$];
    int                     errors;

    function new();
      coef_row[0] = COEF_TOP_RESET;
      coef_row[1] = COEF_MID_RESET;
      coef_row[2] = COEF_BOT_RESET;
      width_reg   = IMG_W_CFG_W'(WIDTH_RESET);
      height_reg  = HEIGHT_RESET;
      foreach (line_upper[i]) begin
        line_upper[i] = '0;
        line_lower[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_COEF_TOP: coef_row[0] = val;
        REG_COEF_MID: coef_row[1] = val;
        REG_COEF_BOT: coef_row[2] = val;
        REG_WIDTH:    width_reg   = val[IMG_W_CFG_W-1:0];
        REG_HEIGHT:   height_reg  = val[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return int'(width_reg);
    endfunction

    function int eff_height();
      return height_reg == 0 ? 1 : int'(height_reg);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // ch 0 is red (top byte); floor then clamp to a pixel
    function logic [PIX_W-1:0] filter(int ch, bit [2:0] row_ok, bit [2:0] col_ok);
      longint acc;
      acc = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          if (row_ok[r] && col_ok[c])
            acc += longint'(win[r][c][RGB_W-PIX_W*(ch+1) +: PIX_W]) *
                   longint'($signed(coef_row[r][COEF_W*c +: COEF_W]));
      if (acc < 0) return '0;
      acc = acc >>> COEF_FRAC_BITS;
      return acc > PIX_MAX ? PIX_W'(PIX_MAX) : PIX_W'(acc);
    endfunction

    function void note_pixel(pix_in_t item);
      int               w, h, col;
      logic [RGB_W-1:0] px, up, lo;
      bit               emit, last;
      bit [2:0]         row_ok, col_ok;
      pix_out_t         res;
      w = eff_width();
      h = eff_height();
      // flush before the first pixel of a frame is dropped outright
      if (item.flush && in_row == 0 && in_col == 0) return;
      px  = item.flush ? '0 : {item.pix_red, item.pix_green, item.pix_blue};
      col = in_col < LINE_DEPTH ? in_col : LINE_DEPTH - 1;
      up  = line_upper[col];
      lo  = line_lower[col];
      line_upper[col] = lo;
      line_lower[col] = px;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = px;
      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
        in_col = 0;
        if (in_row < 'hFFFF) in_row++;
      end else begin
        in_col++;
      end
      if (!emit) return;
      for (int k = 0; k < 3; k++) begin
        row_ok[k] = (out_row + k - 1 >= 0) && (out_row + k - 1 < h);
        col_ok[k] = (out_col + k - 1 >= 0) && (out_col + k - 1 < w);
      end
      last = out_row + 1 >= h && out_col + 1 >= w;
      res.out_red    = filter(0, row_ok, col_ok);
      res.out_green  = filter(1, row_ok, col_ok);
      res.out_blue   = filter(2, row_ok, col_ok);
      res.frame_last = last;
      expected_pixels.push_back(res);
      if (last) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        if (out_row < 'hFFFF) out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b", $time,
                 got.out_red, got.out_green, got.out_blue, got.frame_last);
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                 $time, want.out_red, want.out_green, want.out_blue, want.frame_last,
                 got.out_red, got.out_green, got.out_blue, got.frame_last);
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COEF_TOP;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 px_valid  = 1'b0;
  logic                 px_ready;
  pix_in_t              px_data   = '0;
  logic                 flt_valid;
  logic                 flt_ready = 1'b0;
  pix_out_t             flt_data;

  phase_t               phase     = PH_STEADY;
  logic                 hold_tag  = 1'b0;
  logic                 hold_seen = 1'b0;
  int                   hold_len  = 0;
  int                   hold_left = 0;

  conv3x3_predictor sb = new();

  rgb_conv3x3_zero_pad_unit #(
    .MAX_WIDTH (LINE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .px_valid  (px_valid),
    .px_ready  (px_ready),
    .px_data   (px_data),
    .flt_valid (flt_valid),
    .flt_ready (flt_ready),
    .flt_data  (flt_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit src_idles();
    case (phase)
      PH_SRC_IDLE: return $urandom_range(99) < 69;
      PH_BOTH:     return $urandom_range(99) < 6;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (phase)
      PH_SINK_STALL: return $urandom_range(99) < 69;
      PH_BOTH:       return $urandom_range(99) < 6;
      default:       return 1'b0;
    endcase
  endfunction

  // Result side: random stalls, plus a long hold-off whenever hold_tag toggles
  always @(posedge clk) begin
    if (rst) begin
      flt_ready <= 1'b0;
      hold_seen <= hold_tag;
      hold_left <= 0;
    end else if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= hold_len;
      flt_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      flt_ready <= 1'b0;
    end else begin
      flt_ready <= !sink_stalls();
    end
  end

  // Results are checked before the same-edge input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (flt_valid && flt_ready) sb.check_pixel(flt_data);
      if (px_valid && px_ready) sb.note_pixel(px_data);
    end
  end

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return 16'h0100;
      default: return COEF_W'(int'($urandom_range(128)) - 48);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic pix_in_t make_item(input bit flush, input bit extreme);
    pix_in_t it;
    it.flush     = flush;
    it.pix_red   = extreme ? ($urandom_range(1) ? PIX_W'(PIX_MAX) : '0) : PIX_W'($urandom_range(255));
    it.pix_green = extreme ? ($urandom_range(1) ? PIX_W'(PIX_MAX) : '0) : PIX_W'($urandom_range(255));
    it.pix_blue  = extreme ? ($urandom_range(1) ? PIX_W'(PIX_MAX) : '0) : PIX_W'($urandom_range(255));
    return it;
  endfunction

  // valid is left high on return so back-to-back transactions need no toggle
  task automatic send_item(input pix_in_t item);
    if (src_idles()) begin
      px_valid <= 1'b0;
      do @(posedge clk); while (src_idles());
    end
    px_valid <= 1'b1;
    px_data  <= item;
    do @(posedge clk); while (!px_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] top, input logic [CFG_W-1:0] mid,
                            input logic [CFG_W-1:0] bot, input int width, input int height);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
    write_reg(REG_WIDTH, CFG_W'(width));
    write_reg(REG_HEIGHT, CFG_W'(height));
    cfg_we <= 1'b0;
  endtask

  // Pause input until every owed pixel is out and the pipeline has settled
  task automatic wait_drained();
    px_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One frame: ignored leading flushes, the pixels, then width+1 drain items
  task automatic send_frame(input int lead, input int flush_pct, input int drain_pix_pct,
                            input bit extreme, output int items);
    int w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    repeat (lead) send_item(make_item(1'b1, extreme));
    for (int i = 0; i < w * h; i++)
      send_item(make_item($urandom_range(99) < flush_pct, extreme));
    for (int i = 0; i <= w; i++)
      send_item(make_item(!($urandom_range(99) < drain_pix_pct), extreme));
    items = w * h + w + 1;
  endtask

  initial begin
    int items;
    int random_items;
    int frames;
    int w_sel, h_sel;
    random_items = 0;
    frames       = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero geometry falls back to 1x1; leading flushes are dropped
    set_config('0, 48'h0000_0100_0000, '0, 0, 0);
    send_frame(2, 0, 0, 1'b1, items);
    wait_drained();
    // full positive kernel saturates high, black pixels from flushes
    set_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 2, 2);
    send_frame(0, 50, 0, 1'b1, items);
    wait_drained();
    // full negative kernel, pixels arriving during the drain
    set_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 3, 1);
    send_frame(0, 0, 100, 1'b1, items);
    wait_drained();
    set_config({16'h0040, 16'hFF80, 16'h0040}, {16'hFF00, 16'h0400, 16'hFF00},
               {16'h0040, 16'hFF80, 16'h0040}, 1, 3);
    send_frame(1, 20, 50, 1'b0, items);
    wait_drained();

    // back-pressure: result side held off while the source keeps offering
    set_config(rand_row(), rand_row(), rand_row(), 30, 4);
    hold_len <= 400;
    hold_tag <= ~hold_tag;
    send_frame(0, 10, 15, 1'b0, items);

    while (random_items < RANDOM_ITEMS) begin
      phase <= phase_t'((random_items * 4) / RANDOM_ITEMS);
      if (frames == 0 || $urandom_range(99) < 60) begin
        wait_drained();
        if ($urandom_range(19) < 16) begin
          w_sel = $urandom_range(8, 1);
          h_sel = $urandom_range(6, 1);
        end else begin
          w_sel = $urandom_range(40, 9);
          h_sel = $urandom_range(4, 1);
        end
        set_config(rand_row(), rand_row(), rand_row(), w_sel, h_sel);
      end
      send_frame($urandom_range(4) == 0 ? $urandom_range(3, 1) : 0, 10, 15,
                 $urandom_range(9) == 0, items);
      random_items += items;
      frames++;
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
